// ===== hw/rtl/generational_handle_table_defines.svh =====
// ----------------------------------------------------------------------------
// generational handle table assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// shared widths, codes and control/status structs of the handle table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int HSLOT_W        = 8;
	localparam int GEN_W          = 32;
	localparam int WORD_W         = 32;
	localparam int REC_W          = 4 * WORD_W;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ACQUIRE = 2'd0;
	localparam cmd_t CMD_LOOKUP  = 2'd1;
	localparam cmd_t CMD_RELEASE = 2'd2;

	typedef logic [1:0] sts_t;
	localparam sts_t STS_OK   = 2'd0;
	localparam sts_t STS_FULL = 2'd1;
	localparam sts_t STS_BAD  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic stack_rd;
		logic slot_rd;
		logic exec;
		logic slot_we;
		logic slot_alive;
		logic pop;
		logic push;
		logic open_new;
		logic res_acq;
		logic res_rec;
		sts_t res_status;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic stack_empty;
		logic stack_full;
		logic table_full;
		logic handle_ok;
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ght_ram.sv =====
// ----------------------------------------------------------------------------
// ght_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ght_ctrl.sv =====
// ----------------------------------------------------------------------------
// ght_ctrl
// command sequencer: fetch stack top, read slot, then decide and commit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_ctrl (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	output logic       done,
	input  ght_pkg::stat_t stat,
	output ght_pkg::ctrl_t ctrl
);

	import ght_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_SLOT  = 4'b0100,
		ST_EXEC  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		ctrl.res_status = STS_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.latch = 1'b1;
					state_d    = ST_FETCH;
				end
			end
			ST_FETCH: begin
				ctrl.stack_rd = 1'b1;
				state_d       = ST_SLOT;
			end
			ST_SLOT: begin
				ctrl.slot_rd = 1'b1;
				state_d      = ST_EXEC;
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_d   = ST_IDLE;
				unique case (stat.cmd)
					CMD_ACQUIRE: begin
						if (!stat.stack_empty) begin
							ctrl.slot_we    = 1'b1;
							ctrl.slot_alive = 1'b1;
							ctrl.pop        = 1'b1;
							ctrl.res_acq    = 1'b1;
						end else if (!stat.table_full) begin
							ctrl.slot_we    = 1'b1;
							ctrl.slot_alive = 1'b1;
							ctrl.open_new   = 1'b1;
							ctrl.res_acq    = 1'b1;
						end else begin
							ctrl.res_status = STS_FULL;
						end
					end
					CMD_LOOKUP: begin
						if (stat.handle_ok) begin
							ctrl.res_rec = 1'b1;
						end else begin
							ctrl.res_status = STS_BAD;
						end
					end
					CMD_RELEASE: begin
						if (stat.handle_ok && !stat.stack_full) begin
							ctrl.slot_we = 1'b1;
							ctrl.push    = 1'b1;
						end else begin
							ctrl.res_status = STS_BAD;
						end
					end
					default: begin
						ctrl.res_status = STS_BAD;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.exec;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ght_dp.sv =====
// ----------------------------------------------------------------------------
// ght_dp
// handle table datapath: slot ram, free-index stack, counters, result regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_dp #(
	parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [1:0]                  command,
	input  wire logic [ght_pkg::HSLOT_W-1:0] handle_slot,
	input  wire logic [ght_pkg::GEN_W-1:0]   handle_generation,
	input  wire logic [ght_pkg::WORD_W-1:0]  vtx_offset,
	input  wire logic [ght_pkg::WORD_W-1:0]  vtx_count,
	input  wire logic [ght_pkg::WORD_W-1:0]  idx_offset,
	input  wire logic [ght_pkg::WORD_W-1:0]  idx_count,
	input  ght_pkg::ctrl_t                   ctrl,
	output ght_pkg::stat_t                   stat,
	output logic [1:0]                       status,
	output logic [ght_pkg::HSLOT_W-1:0]      out_slot,
	output logic [ght_pkg::GEN_W-1:0]        out_generation,
	output logic [ght_pkg::WORD_W-1:0]       found_vertex_offset,
	output logic [ght_pkg::WORD_W-1:0]       found_vertex_count,
	output logic [ght_pkg::WORD_W-1:0]       found_index_offset,
	output logic [ght_pkg::WORD_W-1:0]       found_index_count
);

	import ght_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W  = (CNT_W > HSLOT_W) ? CNT_W : HSLOT_W;
	localparam int ENT_W  = 1 + GEN_W + REC_W;

	// latched command
	cmd_t               cmd_q;
	logic [HSLOT_W-1:0] hslot_q;
	logic [GEN_W-1:0]   hgen_q;
	logic [REC_W-1:0]   rec_q;

	logic [CNT_W-1:0]   slots_q;
	logic [CNT_W-1:0]   depth_q;
	logic [SLOT_W-1:0]  idx_q;

	logic [SLOT_W-1:0]  stk_rdata;
	logic [SLOT_W-1:0]  slot_addr;
	logic [ENT_W-1:0]   slot_rdata;
	logic [ENT_W-1:0]   slot_wdata;

	logic               rd_alive;
	logic [GEN_W-1:0]   rd_gen;
	logic [REC_W-1:0]   rd_rec;
	logic [GEN_W-1:0]   gen_wr;
	logic [REC_W-1:0]   rec_wr;
	logic               in_range;

	sts_t               status_q;
	logic [HSLOT_W-1:0] out_slot_q;
	logic [GEN_W-1:0]   out_gen_q;
	logic [REC_W-1:0]   found_q;

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q   <= command;
			hslot_q <= handle_slot;
			hgen_q  <= handle_generation;
			rec_q   <= {idx_count, idx_offset, vtx_count, vtx_offset};
		end
		if (ctrl.slot_rd) begin
			idx_q <= slot_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
			depth_q <= '0;
		end else begin
			if (ctrl.open_new) begin
				slots_q <= slots_q + CNT_W'(1);
			end
			if (ctrl.pop) begin
				depth_q <= depth_q - CNT_W'(1);
			end else if (ctrl.push) begin
				depth_q <= depth_q + CNT_W'(1);
			end
		end
	end

	ght_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_COUNT)
	) u_stack_ram (
		.clk   (clk),
		.we    (ctrl.push),
		.waddr (SLOT_W'(depth_q)),
		.wdata (SLOT_W'(hslot_q)),
		.re    (ctrl.stack_rd),
		.raddr (SLOT_W'(depth_q - CNT_W'(1))),
		.rdata (stk_rdata)
	);

	// acquire takes the stack top, or the next fresh slot when the stack is empty
	always_comb begin
		if (cmd_q == CMD_ACQUIRE) begin
			slot_addr = (depth_q == '0) ? SLOT_W'(slots_q) : stk_rdata;
		end else begin
			slot_addr = SLOT_W'(hslot_q);
		end
	end

	assign rd_alive = slot_rdata[ENT_W-1];
	assign rd_gen   = slot_rdata[REC_W +: GEN_W];
	assign rd_rec   = slot_rdata[REC_W-1:0];

	assign gen_wr = ctrl.pop ? (rd_gen + GEN_W'(1)) : (ctrl.open_new ? '0 : rd_gen);
	assign rec_wr = (ctrl.pop || ctrl.open_new) ? rec_q : rd_rec;
	assign slot_wdata = {ctrl.slot_alive, gen_wr, rec_wr};

	ght_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ctrl.slot_we),
		.waddr (idx_q),
		.wdata (slot_wdata),
		.re    (ctrl.slot_rd),
		.raddr (slot_addr),
		.rdata (slot_rdata)
	);

	assign in_range = (CMP_W'(hslot_q) < CMP_W'(slots_q));

	assign stat.cmd         = cmd_q;
	assign stat.stack_empty = (depth_q == '0);
	assign stat.stack_full  = (depth_q == CNT_W'(SLOT_COUNT));
	assign stat.table_full  = (slots_q == CNT_W'(SLOT_COUNT));
	assign stat.handle_ok   = in_range && rd_alive && (rd_gen == hgen_q);

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			status_q   <= ctrl.res_status;
			out_slot_q <= ctrl.res_acq ? HSLOT_W'(idx_q) : '0;
			out_gen_q  <= ctrl.res_acq ? gen_wr : '0;
			found_q    <= ctrl.res_rec ? rd_rec : '0;
		end
	end

	assign status              = status_q;
	assign out_slot            = out_slot_q;
	assign out_generation      = out_gen_q;
	assign found_vertex_offset = found_q[0*WORD_W +: WORD_W];
	assign found_vertex_count  = found_q[1*WORD_W +: WORD_W];
	assign found_index_offset  = found_q[2*WORD_W +: WORD_W];
	assign found_index_count   = found_q[3*WORD_W +: WORD_W];

endmodule

`default_nettype wire

// ===== hw/rtl/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table
// mesh record table addressed by slot/generation handles
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result appears
// on the result ports with done high for exactly one cycle, once the fetch,
// slot and exec states have passed; the receiver cannot stall it. busy stays
// high through those states, so a new command is taken only once the last
// is through: the free-stack ram read and the slot ram read (both registered)
// run one after the other before the slot is updated. No clearing pass follows
// reset; the table is usable as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_table #(
	parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	output logic                             done,
	input  wire logic [1:0]                  command,
	input  wire logic [ght_pkg::HSLOT_W-1:0] handle_slot,
	input  wire logic [ght_pkg::GEN_W-1:0]   handle_generation,
	input  wire logic [ght_pkg::WORD_W-1:0]  vtx_offset,
	input  wire logic [ght_pkg::WORD_W-1:0]  vtx_count,
	input  wire logic [ght_pkg::WORD_W-1:0]  idx_offset,
	input  wire logic [ght_pkg::WORD_W-1:0]  idx_count,
	output logic [1:0]                       status,
	output logic [ght_pkg::HSLOT_W-1:0]      out_slot,
	output logic [ght_pkg::GEN_W-1:0]        out_generation,
	output logic [ght_pkg::WORD_W-1:0]       found_vertex_offset,
	output logic [ght_pkg::WORD_W-1:0]       found_vertex_count,
	output logic [ght_pkg::WORD_W-1:0]       found_index_offset,
	output logic [ght_pkg::WORD_W-1:0]       found_index_count
);

	import ght_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	ght_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	ght_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.command             (command),
		.handle_slot         (handle_slot),
		.handle_generation   (handle_generation),
		.vtx_offset          (vtx_offset),
		.vtx_count           (vtx_count),
		.idx_offset          (idx_offset),
		.idx_count           (idx_count),
		.ctrl                (ctrl),
		.stat                (stat),
		.status              (status),
		.out_slot            (out_slot),
		.out_generation      (out_generation),
		.found_vertex_offset (found_vertex_offset),
		.found_vertex_count  (found_vertex_count),
		.found_index_offset  (found_index_offset),
		.found_index_count   (found_index_count)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ght_checker.sv =====
// ----------------------------------------------------------------------------
// ght_checker
// port-level checks of the handle table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "generational_handle_table_defines.svh"

module ght_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic                        done,
	input  wire logic [1:0]                  status,
	input  wire logic [ght_pkg::HSLOT_W-1:0] out_slot,
	input  wire logic [ght_pkg::GEN_W-1:0]   out_generation,
	input  wire logic [ght_pkg::WORD_W-1:0]  found_vertex_offset,
	input  wire logic [ght_pkg::WORD_W-1:0]  found_vertex_count,
	input  wire logic [ght_pkg::WORD_W-1:0]  found_index_offset,
	input  wire logic [ght_pkg::WORD_W-1:0]  found_index_count
);

	import ght_pkg::*;

	// every transaction taken gives exactly one result
	`GHT_ASSERT_IMP(a_result_latency, start && !busy, ##4 done, "result missing after command")

	`GHT_ASSERT_NXT(a_busy_after_start, start && !busy, busy && !done, "busy not raised")

	`GHT_ASSERT_IMP(a_done_ends_busy, done, !busy && $past(busy), "result outside a command")

	// failed commands carry no handle and no record
	`GHT_ASSERT_IMP(a_fail_zero, done && status != STS_OK, out_slot == '0 && out_generation == '0 && found_vertex_offset == '0 && found_vertex_count == '0 && found_index_offset == '0 && found_index_count == '0, "failed result not cleared")

	`GHT_ASSERT_IMP(a_status_code, done, status == STS_OK || status == STS_FULL || status == STS_BAD, "unknown status code")

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);

`default_nettype wire

// ===== test/tb_generational_handle_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_table
// self-checking bench for the slot/generation handle table: a short directed
// run covers empty-table lookups, bad and stale handles, slot reuse and the
// unused command. Random episodes then fill the table to overflow, drain it
// and mix commands. Every transaction is predicted at acceptance, and each
// done strobe is checked field by field in order.
// ----------------------------------------------------------------------------

module tb_generational_handle_table;
	import ght_pkg::*;

	localparam int   SLOTS        = SLOT_COUNT_DEF;
	localparam cmd_t CMD_UNUSED   = 2'd3;
	localparam int   RANDOM_ITEMS = 1600;
	localparam int   DRAIN_CYCLES = 8;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [HSLOT_W-1:0] slot;
		logic [GEN_W-1:0]   gen;
		logic [WORD_W-1:0]  vo;
		logic [WORD_W-1:0]  vc;
		logic [WORD_W-1:0]  io;
		logic [WORD_W-1:0]  ic;
		bit                 settle;
	} table_cmd_t;

	typedef struct packed {
		sts_t               status;
		logic [HSLOT_W-1:0] slot;
		logic [GEN_W-1:0]   gen;
		logic [WORD_W-1:0]  vo;
		logic [WORD_W-1:0]  vc;
		logic [WORD_W-1:0]  io;
		logic [WORD_W-1:0]  ic;
	} table_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	cmd_t                command = CMD_ACQUIRE;
	logic [HSLOT_W-1:0]  handle_slot = '0;
	logic [GEN_W-1:0]    handle_generation = '0;
	logic [WORD_W-1:0]   vtx_offset = '0;
	logic [WORD_W-1:0]   vtx_count = '0;
	logic [WORD_W-1:0]   idx_offset = '0;
	logic [WORD_W-1:0]   idx_count = '0;
	logic                busy;
	logic                done;
	logic [1:0]          status;
	logic [HSLOT_W-1:0]  out_slot;
	logic [GEN_W-1:0]    out_generation;
	logic [WORD_W-1:0]   found_vertex_offset;
	logic [WORD_W-1:0]   found_vertex_count;
	logic [WORD_W-1:0]   found_index_offset;
	logic [WORD_W-1:0]   found_index_count;

	generational_handle_table u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.done                (done),
		.command             (command),
		.handle_slot         (handle_slot),
		.handle_generation   (handle_generation),
		.vtx_offset          (vtx_offset),
		.vtx_count           (vtx_count),
		.idx_offset          (idx_offset),
		.idx_count           (idx_count),
		.status              (status),
		.out_slot            (out_slot),
		.out_generation      (out_generation),
		.found_vertex_offset (found_vertex_offset),
		.found_vertex_count  (found_vertex_count),
		.found_index_offset  (found_index_offset),
		.found_index_count   (found_index_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the table
	logic [REC_W-1:0]   slot_rec [SLOTS];
	logic [GEN_W-1:0]   slot_gen [SLOTS];
	bit                 slot_live [SLOTS];
	logic [HSLOT_W-1:0] free_stk [SLOTS];
	int                 slots_open = 0;
	int                 free_depth = 0;

	table_cmd_t    cmd_queue [$];
	table_result_t expected_results [$];
	table_cmd_t    bus_cmd;
	table_result_t want;
	int            mismatches = 0;
	int            results_seen = 0;
	int            n_driven = 0;
	int            n_taken = 0;
	int            gap_left = 0;
	int            no_idle_left = 0;

	function automatic bit handle_matches(logic [HSLOT_W-1:0] s, logic [GEN_W-1:0] g);
		return (int'(s) < slots_open) && slot_live[s] && (slot_gen[s] == g);
	endfunction

	function automatic table_result_t apply_command(table_cmd_t c);
		table_result_t r;
		int            idx;
		r = '0;
		r.status = STS_OK;
		case (c.cmd)
			CMD_ACQUIRE: begin
				if (free_depth > 0) begin
					free_depth--;
					idx = int'(free_stk[free_depth]);
					slot_gen[idx] = slot_gen[idx] + 1'b1;
				end else if (slots_open < SLOTS) begin
					idx = slots_open;
					slots_open++;
					slot_gen[idx] = '0;
				end else begin
					r.status = STS_FULL;
					return r;
				end
				slot_rec[idx] = {c.vo, c.vc, c.io, c.ic};
				slot_live[idx] = 1'b1;
				r.slot = idx[HSLOT_W-1:0];
				r.gen = slot_gen[idx];
			end
			CMD_LOOKUP: begin
				if (handle_matches(c.slot, c.gen))
					{r.vo, r.vc, r.io, r.ic} = slot_rec[c.slot];
				else
					r.status = STS_BAD;
			end
			CMD_RELEASE: begin
				if (handle_matches(c.slot, c.gen) && free_depth < SLOTS) begin
					slot_live[c.slot] = 1'b0;
					free_stk[free_depth] = c.slot;
					free_depth++;
				end else begin
					r.status = STS_BAD;
				end
			end
			default: r.status = STS_BAD;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %h, expected %h", name, got, exp_val));
	endtask

	// mostly short gaps, a few long ones, and now and then a burst with none
	function automatic int pick_gap();
		int r;
		if (no_idle_left > 0) begin
			no_idle_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			no_idle_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			// hold the transaction until it is taken
			if (!(start && n_taken != n_driven)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_queue.size() != 0 &&
						!(cmd_queue[0].settle && expected_results.size() != 0)) begin
					bus_cmd = cmd_queue.pop_front();
					command <= bus_cmd.cmd;
					handle_slot <= bus_cmd.slot;
					handle_generation <= bus_cmd.gen;
					vtx_offset <= bus_cmd.vo;
					vtx_count <= bus_cmd.vc;
					idx_offset <= bus_cmd.io;
					idx_count <= bus_cmd.ic;
					start <= 1'b1;
					n_driven++;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("done with no transaction outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("out_slot", 32'(out_slot), 32'(want.slot));
					check_field("out_generation", out_generation, want.gen);
					check_field("found_vertex_offset", found_vertex_offset, want.vo);
					check_field("found_vertex_count", found_vertex_count, want.vc);
					check_field("found_index_offset", found_index_offset, want.io);
					check_field("found_index_count", found_index_count, want.ic);
				end
			end
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), apply_command(bus_cmd));
				n_taken++;
			end
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic table_cmd_t rand_cmd(cmd_t op);
		table_cmd_t c;
		c.cmd = op;
		c.slot = HSLOT_W'($urandom_range(0, 255));
		c.gen = rand_word();
		c.vo = rand_word();
		c.vc = rand_word();
		c.io = rand_word();
		c.ic = rand_word();
		c.settle = 1'b0;
		return c;
	endfunction

	function automatic table_cmd_t directed_cmd(cmd_t op, logic [HSLOT_W-1:0] s,
			logic [GEN_W-1:0] g, logic [WORD_W-1:0] w);
		table_cmd_t c;
		c.cmd = op;
		c.slot = s;
		c.gen = g;
		c.vo = w;
		c.vc = ~w;
		c.io = w;
		c.ic = ~w;
		c.settle = 1'b0;
		return c;
	endfunction

	// random slot that is currently live (or dead), with its generation
	function automatic bit pick_slot(bit want_live, output logic [HSLOT_W-1:0] s,
			output logic [GEN_W-1:0] g);
		int k;
		int cand;
		s = '0;
		g = '0;
		if (slots_open == 0)
			return 1'b0;
		for (k = 0; k < 16; k++) begin
			cand = $urandom_range(0, slots_open - 1);
			if (slot_live[cand] == want_live) begin
				s = cand[HSLOT_W-1:0];
				g = slot_gen[cand];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic table_cmd_t live_cmd(cmd_t op);
		table_cmd_t         c;
		logic [HSLOT_W-1:0] s;
		logic [GEN_W-1:0]   g;
		c = rand_cmd(op);
		if (pick_slot(1'b1, s, g)) begin
			c.slot = s;
			c.gen = g;
		end
		return c;
	endfunction

	function automatic table_cmd_t noise_cmd();
		table_cmd_t         c;
		logic [HSLOT_W-1:0] s;
		logic [GEN_W-1:0]   g;
		c = rand_cmd($urandom_range(0, 1) ? CMD_LOOKUP : CMD_RELEASE);
		case ($urandom_range(0, 5))
			0: ;
			1: begin
				// live slot, generation off by one bit
				if (pick_slot(1'b1, s, g)) begin
					c.slot = s;
					c.gen = g ^ (32'd1 << $urandom_range(0, 31));
				end
			end
			2: begin
				// stale handle of a released slot
				if (pick_slot(1'b0, s, g)) begin
					c.slot = s;
					c.gen = g;
				end
			end
			3: c.cmd = CMD_UNUSED;
			4: begin
				if (slots_open < SLOTS) begin
					c.slot = HSLOT_W'($urandom_range(slots_open, SLOTS - 1));
					c.gen = GEN_W'($urandom_range(0, 2));
				end
			end
			default: c.cmd = CMD_ACQUIRE;
		endcase
		return c;
	endfunction

	task automatic push_cmd(table_cmd_t c);
		// keep the queue shallow so that picked handles stay current
		while (cmd_queue.size() != 0) begin
			@(posedge clk);
			#2;
		end
		cmd_queue.insert(cmd_queue.size(), c);
	endtask

	initial begin
		#(64'd10_000_000);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		table_cmd_t c;
		mix_t       mode;
		int         n_rand;
		int         len;
		int         ep;
		int         i;
		int         r;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, unused command
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd0, 32'd0, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_RELEASE, 8'd0, 32'd0, 32'hFFFF_FFFF));
		push_cmd(directed_cmd(CMD_UNUSED, 8'd0, 32'd0, 32'h0000_0000));
		// open two slots, extremes of the record
		push_cmd(directed_cmd(CMD_ACQUIRE, 8'd0, 32'd0, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd0, 32'd0, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd1, 32'd0, 32'hFFFF_FFFF));
		// wrong generation, slot never opened
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd1, 32'hFFFF_FFFF, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_LOOKUP, 8'hFF, 32'd0, 32'hFFFF_FFFF));
		push_cmd(directed_cmd(CMD_RELEASE, 8'd1, 32'd1, 32'h0000_0000));
		// release, then the dead slot is refused
		push_cmd(directed_cmd(CMD_RELEASE, 8'd1, 32'd0, 32'hFFFF_FFFF));
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd1, 32'd0, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_RELEASE, 8'd1, 32'd0, 32'hFFFF_FFFF));
		// reuse bumps the generation, old handle goes stale
		push_cmd(directed_cmd(CMD_ACQUIRE, 8'd0, 32'd0, 32'hA5A5_5A5A));
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd1, 32'd0, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd1, 32'd1, 32'hFFFF_FFFF));
		// stack order: last released comes back first
		push_cmd(directed_cmd(CMD_RELEASE, 8'd0, 32'd0, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_RELEASE, 8'd1, 32'd1, 32'hFFFF_FFFF));
		push_cmd(directed_cmd(CMD_ACQUIRE, 8'd0, 32'd0, 32'h1234_5678));
		push_cmd(directed_cmd(CMD_ACQUIRE, 8'd0, 32'd0, 32'h8765_4321));
		push_cmd(directed_cmd(CMD_ACQUIRE, 8'd0, 32'd0, 32'hFFFF_0000));
		push_cmd(directed_cmd(CMD_LOOKUP, 8'd0, 32'd1, 32'h0000_0000));
		push_cmd(directed_cmd(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

		// random episodes; the first one fills the table past full
		n_rand = 0;
		ep = 0;
		while (n_rand < RANDOM_ITEMS) begin
			mode = (ep == 0) ? MODE_FILL : mix_t'($urandom_range(0, 2));
			len = (ep == 0) ? 330 : $urandom_range(30, 250);
			for (i = 0; i < len && n_rand < RANDOM_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				case (mode)
					MODE_FILL: begin
						if (r < 82)
							c = rand_cmd(CMD_ACQUIRE);
						else if (r < 92)
							c = live_cmd(CMD_LOOKUP);
						else
							c = noise_cmd();
					end
					MODE_DRAIN: begin
						if (r < 60)
							c = live_cmd(CMD_RELEASE);
						else if (r < 75)
							c = live_cmd(CMD_LOOKUP);
						else if (r < 85)
							c = rand_cmd(CMD_ACQUIRE);
						else
							c = noise_cmd();
					end
					default: begin
						if (r < 35)
							c = rand_cmd(CMD_ACQUIRE);
						else if (r < 60)
							c = live_cmd(CMD_LOOKUP);
						else if (r < 80)
							c = live_cmd(CMD_RELEASE);
						else
							c = noise_cmd();
					end
				endcase
				c.settle = (i == 0) && (ep == 0 || $urandom_range(0, 3) == 0);
				push_cmd(c);
				n_rand++;
			end
			ep++;
		end

		while (cmd_queue.size() != 0 || n_taken != n_driven || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
